/* rtl/isl_pkg.sv */
// Shared types and constants for the indexed shift list.
`default_nettype none

package isl_pkg;

    // Default and sizing constants
    localparam int DEFAULT_CAPACITY = 64;
    localparam int WORD_W           = 32;
    localparam int POS_W            = 8;
    localparam int FILL_OUT_W       = 7;
    // Wide enough for any index or fill count up to the largest capacity (1024)
    localparam int CMD_W            = 11;

    // Request kinds as coded on the request channel
    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_INSERT     = 3'd2,
        REQ_REMOVE     = 3'd3,
        REQ_RANGE      = 3'd4,
        REQ_READ       = 3'd5,
        REQ_WRITE      = 3'd6
    } t_req_kind;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // Per-cycle action broadcast to every cell
    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_LOAD = 2'd1,
        SH_UP   = 2'd2,
        SH_DOWN = 2'd3
    } t_shift_op;

    typedef struct packed {
        t_shift_op          op;
        logic [CMD_W-1:0]   pos;
        logic [CMD_W-1:0]   fill;
        logic [WORD_W-1:0]  word;
    } t_cell_cmd;

    // Controller states
    typedef enum logic {
        FSM_IDLE  = 1'b0,
        FSM_RANGE = 1'b1
    } t_fsm_state;

endpackage

`default_nettype wire

/* rtl/isl_cell.sv */
// One slot of the list: holds a word and moves it to or from its neighbors.
`default_nettype none

module isl_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire isl_pkg::t_cell_cmd          i_cmd,
    input  wire logic [isl_pkg::WORD_W-1:0]  i_left,
    input  wire logic [isl_pkg::WORD_W-1:0]  i_right,
    output logic      [isl_pkg::WORD_W-1:0]  o_word
);

    localparam logic [isl_pkg::CMD_W-1:0] MY_IDX    = isl_pkg::CMD_W'(INDEX);
    localparam logic [isl_pkg::CMD_W-1:0] MY_IDX_P1 = isl_pkg::CMD_W'(INDEX + 1);

    logic [isl_pkg::WORD_W-1:0] r_word;
    logic [isl_pkg::WORD_W-1:0] n_word;

    // Pick this slot's next value from the broadcast action
    always_comb begin
        n_word = r_word;
        case (i_cmd.op)
            isl_pkg::SH_LOAD: begin
                if (i_cmd.pos == MY_IDX) begin
                    n_word = i_cmd.word;
                end
            end
            isl_pkg::SH_UP: begin
                if (i_cmd.pos == MY_IDX) begin
                    n_word = i_cmd.word;
                end else if (MY_IDX > i_cmd.pos && MY_IDX <= i_cmd.fill) begin
                    n_word = i_left;
                end
            end
            isl_pkg::SH_DOWN: begin
                if (MY_IDX >= i_cmd.pos && MY_IDX_P1 == i_cmd.fill) begin
                    n_word = '0;
                end else if (MY_IDX >= i_cmd.pos && MY_IDX_P1 < i_cmd.fill) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // Hold the slot, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

/* rtl/isl_row.sv */
// Row of slot cells chained left to right, with the slot read port.
`default_nettype none

module isl_row #(
    parameter int CAPACITY = isl_pkg::DEFAULT_CAPACITY,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire isl_pkg::t_cell_cmd          i_cmd,
    input  wire logic [IW-1:0]               i_rd_addr,
    output logic      [isl_pkg::WORD_W-1:0]  o_rd_word
);

    logic [isl_pkg::WORD_W-1:0] w_slot [CAPACITY];

    // Chain the cells; the ends see zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [isl_pkg::WORD_W-1:0] w_left;
        logic [isl_pkg::WORD_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_slot[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_slot[g+1];
        end

        isl_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_slot[g])
        );
    end

    // Select the addressed slot
    assign o_rd_word = w_slot[i_rd_addr];

endmodule

`default_nettype wire

/* rtl/indexed_shift_list.sv */
// Top level of the indexed shift list: request decode, control and result register.
//
// Ordered list of signed 32-bit words, CAPACITY slots, built as a row of cells
// that each hold one slot and shift in step with their neighbors.
// Request channel: i_in_valid / o_in_ready with req_type, position, range_end
// and word_in. Result channel: o_out_valid / i_out_ready with status, word_out
// and fill_after. Every request gives exactly one result.
// Timing: for every request but a range removal of more than one word, the result
// is registered and valid in the cycle after the request is accepted. A range
// removal of span words moves the row one place per cycle; its first place moves
// as it is accepted, and its result is registered after the last place.
// Throughput: one request per cycle while results are taken, except that a range
// removal holds off the next request until its last place has moved.
// A finished result waits in the result register; while it is not taken the
// next request is not accepted, and nothing in the list changes.
// Reset clears every slot to zero and the fill count to zero, and empties
// the result register.
`default_nettype none

module indexed_shift_list #(
    parameter int CAPACITY = isl_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [2:0]                      i_req_type,
    input  wire logic [isl_pkg::POS_W-1:0]       i_position,
    input  wire logic [isl_pkg::POS_W-1:0]       i_range_end,
    input  wire logic signed [isl_pkg::WORD_W-1:0] i_word_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [1:0]                           o_status,
    output logic signed [isl_pkg::WORD_W-1:0]    o_word_out,
    output logic [isl_pkg::FILL_OUT_W-1:0]       o_fill_after
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = isl_pkg::CMD_W;
    localparam logic [CW-1:0] CAP_E = CW'(CAPACITY);

    // Control state
    isl_pkg::t_fsm_state         r_state, n_state;
    logic [FW-1:0]               r_fill, n_fill;
    logic [isl_pkg::POS_W-1:0]   r_lo, n_lo;
    logic [isl_pkg::POS_W-1:0]   r_left, n_left;

    // Result register
    logic                        r_out_valid, n_out_valid;
    isl_pkg::t_status            r_status, n_status;
    logic [isl_pkg::WORD_W-1:0]  r_word, n_word;
    logic [isl_pkg::FILL_OUT_W-1:0] r_fill_out, n_fill_out;

    // Decode signals
    isl_pkg::t_req_kind          w_kind;
    logic [CW-1:0]               w_fill_e;
    logic [CW-1:0]               w_pos_e;
    logic [CW-1:0]               w_end_e;
    logic [isl_pkg::POS_W-1:0]   w_lo;
    logic [isl_pkg::POS_W-1:0]   w_span;
    logic                        w_accept;
    logic                        w_multi;
    isl_pkg::t_status            w_dec_status;
    isl_pkg::t_cell_cmd          w_dec_cmd;
    logic [CW-1:0]               w_dec_fill;
    isl_pkg::t_cell_cmd          w_cmd;
    logic [isl_pkg::WORD_W-1:0]  w_rd_word;
    logic                        w_last_step;

    assign w_kind   = isl_pkg::t_req_kind'(i_req_type);
    assign w_fill_e = CW'(r_fill);
    assign w_pos_e  = CW'(i_position);
    assign w_end_e  = CW'(i_range_end);
    assign w_lo     = (i_position < i_range_end) ? i_position : i_range_end;
    assign w_span   = (i_position < i_range_end) ? (i_range_end - i_position)
                                                 : (i_position - i_range_end);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_last_step = (r_left == isl_pkg::POS_W'(1));

    // Decode the request into a row action, a status and the new fill
    always_comb begin
        w_dec_status   = isl_pkg::ST_DONE;
        w_dec_cmd.op   = isl_pkg::SH_HOLD;
        w_dec_cmd.pos  = w_pos_e;
        w_dec_cmd.fill = w_fill_e;
        w_dec_cmd.word = i_word_in;
        w_dec_fill     = w_fill_e;
        w_multi        = 1'b0;
        unique case (w_kind)
            isl_pkg::REQ_PUSH_BACK: begin
                if (w_fill_e >= CAP_E) begin
                    w_dec_status = isl_pkg::ST_FULL;
                end else begin
                    w_dec_cmd.op  = isl_pkg::SH_LOAD;
                    w_dec_cmd.pos = w_fill_e;
                    w_dec_fill    = w_fill_e + CW'(1);
                end
            end
            isl_pkg::REQ_PUSH_FRONT: begin
                if (w_fill_e >= CAP_E) begin
                    w_dec_status = isl_pkg::ST_FULL;
                end else begin
                    w_dec_cmd.op  = isl_pkg::SH_UP;
                    w_dec_cmd.pos = '0;
                    w_dec_fill    = w_fill_e + CW'(1);
                end
            end
            isl_pkg::REQ_INSERT: begin
                if (w_pos_e >= w_fill_e) begin
                    w_dec_status = isl_pkg::ST_BAD;
                end else if (w_fill_e >= CAP_E) begin
                    w_dec_status = isl_pkg::ST_FULL;
                end else begin
                    w_dec_cmd.op = isl_pkg::SH_UP;
                    w_dec_fill   = w_fill_e + CW'(1);
                end
            end
            isl_pkg::REQ_REMOVE: begin
                if (w_pos_e >= w_fill_e) begin
                    w_dec_status = isl_pkg::ST_BAD;
                end else begin
                    w_dec_cmd.op = isl_pkg::SH_DOWN;
                    w_dec_fill   = w_fill_e - CW'(1);
                end
            end
            isl_pkg::REQ_RANGE: begin
                if (w_pos_e >= w_fill_e || w_end_e >= w_fill_e
                    || i_position == i_range_end) begin
                    w_dec_status = isl_pkg::ST_BAD;
                end else begin
                    // First one-place removal now; the rest follow one per cycle
                    w_dec_cmd.op  = isl_pkg::SH_DOWN;
                    w_dec_cmd.pos = CW'(w_lo);
                    w_dec_fill    = w_fill_e - CW'(1);
                    w_multi       = (w_span > isl_pkg::POS_W'(1));
                end
            end
            isl_pkg::REQ_READ: begin
                if (w_pos_e >= CAP_E) begin
                    w_dec_status = isl_pkg::ST_BAD;
                end
            end
            isl_pkg::REQ_WRITE: begin
                if (w_pos_e >= CAP_E) begin
                    w_dec_status = isl_pkg::ST_BAD;
                end else begin
                    w_dec_cmd.op = isl_pkg::SH_LOAD;
                end
            end
            default: begin
                w_dec_status = isl_pkg::ST_BAD;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isl_pkg::FSM_IDLE: begin
                if (w_accept && w_multi) begin
                    n_state = isl_pkg::FSM_RANGE;
                end
            end
            isl_pkg::FSM_RANGE: begin
                if (w_last_step) begin
                    n_state = isl_pkg::FSM_IDLE;
                end
            end
            default: begin
                n_state = isl_pkg::FSM_IDLE;
            end
        endcase
    end

    // Outputs of the controller: ready and the row action
    always_comb begin
        o_in_ready = 1'b0;
        w_cmd      = '{op: isl_pkg::SH_HOLD, pos: '0, fill: w_fill_e, word: '0};
        unique case (r_state)
            isl_pkg::FSM_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                if (w_accept) begin
                    w_cmd = w_dec_cmd;
                end
            end
            isl_pkg::FSM_RANGE: begin
                w_cmd = '{op: isl_pkg::SH_DOWN, pos: CW'(r_lo), fill: w_fill_e, word: '0};
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Advance fill count, range counters and the result register
    always_comb begin
        n_fill      = r_fill;
        n_lo        = r_lo;
        n_left      = r_left;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_word      = r_word;
        n_fill_out  = r_fill_out;
        if (r_state == isl_pkg::FSM_RANGE) begin
            n_fill = r_fill - FW'(1);
            n_left = r_left - isl_pkg::POS_W'(1);
            if (w_last_step) begin
                n_out_valid = 1'b1;
                n_status    = isl_pkg::ST_DONE;
                n_word      = '0;
                n_fill_out  = isl_pkg::FILL_OUT_W'(w_fill_e - CW'(1));
            end
        end else if (w_accept) begin
            n_fill = FW'(w_dec_fill);
            n_lo   = w_lo;
            n_left = w_span - isl_pkg::POS_W'(1);
            if (!w_multi) begin
                n_out_valid = 1'b1;
                n_status    = w_dec_status;
                n_word      = (w_kind == isl_pkg::REQ_READ && w_dec_status == isl_pkg::ST_DONE)
                              ? w_rd_word : '0;
                n_fill_out  = isl_pkg::FILL_OUT_W'(w_dec_fill);
            end
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isl_pkg::FSM_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_left     <= n_left;
        r_status   <= n_status;
        r_word     <= n_word;
        r_fill_out <= n_fill_out;
    end

    // Row of slot cells
    isl_row #(
        .CAPACITY (CAPACITY)
    ) u_row (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_rd_addr (w_pos_e[IW-1:0]),
        .o_rd_word (w_rd_word)
    );

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_word_out   = r_word;
    assign o_fill_after = r_fill_out;

endmodule

`default_nettype wire

/* verif/indexed_shift_list_test.sv */
// Self-checking testbench for the indexed shift list: directed table, then random requests.
`timescale 1ns / 100ps

module indexed_shift_list_test;

    localparam int          CAPACITY     = isl_pkg::DEFAULT_CAPACITY;
    localparam int          RANDOM_ITEMS = 930;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 80;
    // Request code with no defined kind
    localparam logic [2:0]  REQ_SPARE    = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  pos;
        logic [7:0]  stop;
        logic [31:0] word;
    } t_list_req;

    typedef struct packed {
        isl_pkg::t_status status;
        logic [31:0]      word;
        logic [6:0]       fill;
    } t_list_rsp;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       pos;
        logic [7:0]       stop;
        logic [31:0]      word;
        logic             typed;
        isl_pkg::t_status status;
        logic [31:0]      rd;
        logic [6:0]       fill;
    } t_plan_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [2:0]  i_req_type  = '0;
    logic [7:0]  i_position  = '0;
    logic [7:0]  i_range_end = '0;
    logic signed [31:0] i_word_in = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic signed [31:0] o_word_out;
    logic [6:0]  o_fill_after;

    // Shadow copy of the list
    logic [31:0] shadow_slots [CAPACITY];
    int unsigned shadow_fill = 0;
    int unsigned peak_fill   = 0;
    int unsigned ranges_done = 0;

    t_list_rsp   replies_due [$];
    int unsigned mismatches  = 0;
    int unsigned replies_seen = 0;
    int unsigned done_count  = 0;
    int unsigned full_count  = 0;
    int unsigned bad_count   = 0;
    int unsigned stall_cycles = 0;
    bit          steady      = 1'b0;

    // Directed requests; typed rows carry an expectation read straight off the list rules
    t_plan_row directed_plan [23] = '{
        '{isl_pkg::REQ_READ, 8'd0, 8'd0, 32'h0, 1'b1, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_REMOVE, 8'd0, 8'd0, 32'h0, 1'b1, isl_pkg::ST_BAD, 32'h0, 7'd0},
        '{isl_pkg::REQ_INSERT, 8'd0, 8'd0, 32'h5, 1'b1, isl_pkg::ST_BAD, 32'h0, 7'd0},
        '{isl_pkg::REQ_RANGE, 8'd0, 8'd1, 32'h0, 1'b1, isl_pkg::ST_BAD, 32'h0, 7'd0},
        '{REQ_SPARE, 8'd0, 8'd0, 32'h0, 1'b1, isl_pkg::ST_BAD, 32'h0, 7'd0},
        '{isl_pkg::REQ_READ, 8'd255, 8'd0, 32'h0, 1'b1, isl_pkg::ST_BAD, 32'h0, 7'd0},
        '{isl_pkg::REQ_WRITE, 8'd255, 8'd0, 32'hFFFFFFFF, 1'b1, isl_pkg::ST_BAD, 32'h0, 7'd0},
        '{isl_pkg::REQ_WRITE, 8'd63, 8'd0, 32'h7FFFFFFF, 1'b1, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_READ, 8'd63, 8'd0, 32'h0, 1'b1, isl_pkg::ST_DONE, 32'h7FFFFFFF, 7'd0},
        '{isl_pkg::REQ_READ, 8'd64, 8'd0, 32'h0, 1'b1, isl_pkg::ST_BAD, 32'h0, 7'd0},
        '{isl_pkg::REQ_PUSH_BACK, 8'd0, 8'd0, 32'h80000000, 1'b1, isl_pkg::ST_DONE, 32'h0, 7'd1},
        '{isl_pkg::REQ_PUSH_FRONT, 8'd0, 8'd0, 32'hFFFFFFFF, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_INSERT, 8'd1, 8'd0, 32'h12345678, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_INSERT, 8'd3, 8'd0, 32'h0, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_READ, 8'd2, 8'd0, 32'h0, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_READ, 8'd3, 8'd0, 32'h0, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_RANGE, 8'd2, 8'd0, 32'h0, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_RANGE, 8'd0, 8'd0, 32'h0, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_READ, 8'd1, 8'd0, 32'h0, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_WRITE, 8'd5, 8'd0, 32'h55AA55AA, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_REMOVE, 8'd0, 8'd0, 32'h0, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_PUSH_FRONT, 8'd0, 8'd0, 32'h0, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0},
        '{isl_pkg::REQ_RANGE, 8'd255, 8'd0, 32'h0, 1'b0, isl_pkg::ST_DONE, 32'h0, 7'd0}
    };

    indexed_shift_list #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_range_end (i_range_end),
        .i_word_in   (i_word_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_word_out  (o_word_out),
        .o_fill_after(o_fill_after)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        foreach (shadow_slots[k]) shadow_slots[k] = '0;
    end

    // Close a gap of span words starting at lo and clear the vacated tail
    function automatic void shadow_drop(input int unsigned lo, input int unsigned span);
        int unsigned i;
        for (i = lo; i + span < shadow_fill; i++) shadow_slots[i] = shadow_slots[i + span];
        for (i = shadow_fill - span; i < shadow_fill; i++) shadow_slots[i] = '0;
        shadow_fill -= span;
    endfunction

    // Open slot at, shifting every held word above it up by one
    function automatic void shadow_open(input int unsigned at);
        int unsigned i;
        for (i = shadow_fill; i > at; i--) shadow_slots[i] = shadow_slots[i - 1];
        shadow_fill++;
    endfunction

    // Apply one request to the shadow list and return the reply it owes
    function automatic t_list_rsp shadow_apply(input t_list_req req);
        t_list_rsp   rsp;
        int unsigned lo;
        int unsigned hi;
        rsp = '{isl_pkg::ST_DONE, 32'h0, 7'd0};
        case (req.kind)
            isl_pkg::REQ_PUSH_BACK: begin
                if (shadow_fill >= CAPACITY) begin
                    rsp.status = isl_pkg::ST_FULL;
                end else begin
                    shadow_slots[shadow_fill] = req.word;
                    shadow_fill++;
                end
            end
            isl_pkg::REQ_PUSH_FRONT: begin
                if (shadow_fill >= CAPACITY) begin
                    rsp.status = isl_pkg::ST_FULL;
                end else begin
                    shadow_open(0);
                    shadow_slots[0] = req.word;
                end
            end
            isl_pkg::REQ_INSERT: begin
                if (req.pos >= shadow_fill) begin
                    rsp.status = isl_pkg::ST_BAD;
                end else if (shadow_fill >= CAPACITY) begin
                    rsp.status = isl_pkg::ST_FULL;
                end else begin
                    shadow_open(req.pos);
                    shadow_slots[req.pos] = req.word;
                end
            end
            isl_pkg::REQ_REMOVE: begin
                if (req.pos >= shadow_fill) rsp.status = isl_pkg::ST_BAD;
                else shadow_drop(req.pos, 1);
            end
            isl_pkg::REQ_RANGE: begin
                if (req.pos >= shadow_fill || req.stop >= shadow_fill
                    || req.pos == req.stop) begin
                    rsp.status = isl_pkg::ST_BAD;
                end else begin
                    lo = (req.pos < req.stop) ? req.pos : req.stop;
                    hi = (req.pos < req.stop) ? req.stop : req.pos;
                    shadow_drop(lo, hi - lo);
                    ranges_done++;
                end
            end
            isl_pkg::REQ_READ: begin
                if (req.pos >= CAPACITY) rsp.status = isl_pkg::ST_BAD;
                else rsp.word = shadow_slots[req.pos];
            end
            isl_pkg::REQ_WRITE: begin
                if (req.pos >= CAPACITY) rsp.status = isl_pkg::ST_BAD;
                else shadow_slots[req.pos] = req.word;
            end
            default: begin
                rsp.status = isl_pkg::ST_BAD;
            end
        endcase
        rsp.fill = shadow_fill[6:0];
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
        return rsp;
    endfunction

    // Mostly random words, with the signed extremes now and then
    function automatic logic [31:0] pick_word();
        case ($urandom_range(19))
            0:       return 32'h80000000;
            1:       return 32'h7FFFFFFF;
            2:       return 32'h0;
            3:       return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    // Index inside the held list most of the time, anywhere in the field otherwise
    function automatic logic [7:0] pick_held_index();
        if (shadow_fill > 0 && $urandom_range(9) < 8) return 8'($urandom_range(shadow_fill - 1));
        return 8'($urandom_range(255));
    endfunction

    function automatic t_list_req pick_request();
        t_list_req   req;
        int unsigned roll;
        roll     = $urandom_range(99);
        req.word = pick_word();
        req.pos  = 8'($urandom_range(255));
        req.stop = 8'($urandom_range(255));
        if (roll < 18)       req.kind = isl_pkg::REQ_PUSH_BACK;
        else if (roll < 30)  req.kind = isl_pkg::REQ_PUSH_FRONT;
        else if (roll < 45)  req.kind = isl_pkg::REQ_INSERT;
        else if (roll < 57)  req.kind = isl_pkg::REQ_REMOVE;
        else if (roll < 65)  req.kind = isl_pkg::REQ_RANGE;
        else if (roll < 80)  req.kind = isl_pkg::REQ_READ;
        else if (roll < 95)  req.kind = isl_pkg::REQ_WRITE;
        else                 req.kind = REQ_SPARE;
        case (req.kind) inside
            isl_pkg::REQ_INSERT, isl_pkg::REQ_REMOVE: begin
                req.pos = pick_held_index();
            end
            isl_pkg::REQ_RANGE: begin
                req.pos  = pick_held_index();
                req.stop = pick_held_index();
            end
            isl_pkg::REQ_READ, isl_pkg::REQ_WRITE: begin
                if ($urandom_range(99) < 85) req.pos = 8'($urandom_range(CAPACITY - 1));
            end
            default: begin
            end
        endcase
        return req;
    endfunction

    // Growing request: push at either end or insert inside the list
    function automatic t_list_req pick_growth();
        t_list_req req;
        req.word = pick_word();
        req.stop = 8'($urandom_range(255));
        req.pos  = (shadow_fill > 0) ? 8'($urandom_range(shadow_fill - 1)) : 8'd0;
        case ($urandom_range(2))
            0:       req.kind = isl_pkg::REQ_PUSH_BACK;
            1:       req.kind = isl_pkg::REQ_PUSH_FRONT;
            default: req.kind = (shadow_fill > 0) ? isl_pkg::REQ_INSERT : isl_pkg::REQ_PUSH_BACK;
        endcase
        return req;
    endfunction

    // Offer one request, hold it until taken, then log the reply it owes
    task automatic send_request(input t_list_req req, input bit typed, input t_list_rsp typed_rsp);
        t_list_rsp due;
        if (!steady && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req.kind;
        i_position  <= req.pos;
        i_range_end <= req.stop;
        i_word_in   <= req.word;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        due = shadow_apply(req);
        replies_due.push_back(typed ? typed_rsp : due);
    endtask

    // Take replies and compare each field against the oldest one owed
    always @(posedge i_clk) begin
        t_list_rsp due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            replies_seen++;
            case (o_status)
                isl_pkg::ST_DONE: done_count++;
                isl_pkg::ST_FULL: full_count++;
                default:          bad_count++;
            endcase
            if (replies_due.size() == 0) begin
                $display("%0t: reply with none owed: status %0d word %h fill %0d",
                         $time, o_status, o_word_out, o_fill_after);
                mismatches++;
            end else begin
                due = replies_due.pop_front();
                if (o_status !== due.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, due.status, o_status);
                    mismatches++;
                end
                if (o_word_out !== due.word) begin
                    $display("%0t: word_out expected %h actual %h", $time, due.word, o_word_out);
                    mismatches++;
                end
                if (o_fill_after !== due.fill) begin
                    $display("%0t: fill_after expected %0d actual %0d",
                             $time, due.fill, o_fill_after);
                    mismatches++;
                end
            end
        end
        i_out_ready <= steady || ($urandom_range(99) >= 7);
    end

    // Abort when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("Stalled for %0d cycles with %0d replies owed", STALL_LIMIT,
                     replies_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_list_req   req;
        t_list_rsp   typed_rsp;
        int unsigned sent;
        int unsigned next_burst;
        int          j;
        sent       = 0;
        next_burst = 150;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (directed_plan[k]) begin
            req       = '{directed_plan[k].kind, directed_plan[k].pos,
                          directed_plan[k].stop, directed_plan[k].word};
            typed_rsp = '{directed_plan[k].status, directed_plan[k].rd, directed_plan[k].fill};
            send_request(req, directed_plan[k].typed, typed_rsp);
        end

        // Random traffic with periodic fills to capacity
        while (sent < RANDOM_ITEMS) begin
            steady = (sent >= 400 && sent < 560);
            if (sent >= next_burst) begin
                next_burst += 300;
                while (shadow_fill < CAPACITY) begin
                    send_request(pick_growth(), 1'b0, '0);
                    sent++;
                end
                // Hit the full list with four more growing requests of random kind
                for (j = 0; j < 4; j++) begin
                    req = pick_growth();
                    send_request(req, 1'b0, '0);
                    sent++;
                end
            end else begin
                send_request(pick_request(), 1'b0, '0);
                sent++;
            end
        end
        steady = 1'b0;
        i_in_valid <= 1'b0;

        // Drain owed replies, then watch for strays
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d done, %0d refused as full, %0d bad or ignored",
                 replies_seen, done_count, full_count, bad_count);
        $display("List peaked at %0d of %0d slots; %0d range removals completed",
                 peak_fill, CAPACITY, ranges_done);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/isl_pkg.sv
rtl/isl_cell.sv
rtl/isl_row.sv
rtl/indexed_shift_list.sv
verif/indexed_shift_list_test.sv
